// ===== sv/ccbc_pkg.sv =====
// Shared types, codes and constants for the cell chain bin checker.
package ccbc_pkg;

    localparam logic [31:0] HEADER_BYTES    = 32'd32;
    localparam logic [31:0] OLD_USER_OFFSET = 32'd8;
    localparam logic [31:0] NEW_USER_OFFSET = 32'd4;
    localparam logic [31:0] NIL_LINK        = 32'hFFFF_FFFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_START  = 2'd1,
        CMD_CELL   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_BUSY           = 4'd0,
        ST_BIN_OK         = 4'd1,
        ST_BAD_FIRST_LINK = 4'd2,
        ST_BAD_LINK       = 4'd3,
        ST_BAD_ALLOC      = 4'd4,
        ST_ALLOC_OVERFLOW = 4'd5,
        ST_BAD_FREE       = 4'd6,
        ST_FREE_OVERFLOW  = 4'd7,
        ST_NO_BIN         = 4'd8
    } status_t;

    // Operation decided by the front end for each word.
    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_NOP        = 3'd1,
        OP_START_OPEN = 3'd2,
        OP_START_DONE = 3'd3,
        OP_START_BAD  = 3'd4,
        OP_CELL       = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_OPEN = 3'b010,
        PH_FAIL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        bin_size;
        logic signed [31:0] cell_size;
        logic [31:0]        back_link;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] cell_offset;
        logic [31:0] user_bytes;
    } out_word_t;

    // Classified word as it waits in the queue.
    typedef struct packed {
        op_t         op;
        logic [31:0] bin_size;
        logic        alloc;
        logic [31:0] mag;
        logic [31:0] user_delta;
        logic [31:0] back_link;
    } entry_t;

endpackage

// ===== sv/ccbc_front.sv =====
// Front end: accepts input words and classifies them into queue entries.
module ccbc_front
    import ccbc_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     old_format,
    output logic     push_valid,
    input  logic     push_ready,
    output entry_t   push_entry
);

    logic [31:0] raw;
    logic [31:0] uoff;

    assign raw        = in_word.cell_size;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign uoff       = old_format ? OLD_USER_OFFSET : NEW_USER_OFFSET;

    always_comb
    begin
        push_entry.bin_size   = in_word.bin_size;
        push_entry.back_link  = in_word.back_link;
        push_entry.alloc      = raw[31];
        // The most negative size has magnitude 2^31, which the unsigned
        // negate gives directly.
        push_entry.mag        = raw[31] ? (32'd0 - raw) : raw;
        push_entry.user_delta = push_entry.mag - uoff;
        case (in_word.command)
            CMD_CLEAR:
            begin
                push_entry.op = OP_CLEAR;
            end
            CMD_START:
            begin
                if (in_word.bin_size > HEADER_BYTES)
                begin
                    push_entry.op = OP_START_OPEN;
                end
                else if (in_word.bin_size == HEADER_BYTES)
                begin
                    push_entry.op = OP_START_DONE;
                end
                else
                begin
                    push_entry.op = OP_START_BAD;
                end
            end
            CMD_CELL:
            begin
                push_entry.op = OP_CELL;
            end
            default:
            begin
                push_entry.op = OP_NOP;
            end
        endcase
    end

endmodule

// ===== sv/ccbc_fifo.sv =====
// Short queue of classified entries between the front and back ends.
module ccbc_fifo
    import ccbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/ccbc_back.sv =====
// Back end: walks the cell chain, keeps the bin state and registers results.
module ccbc_back
    import ccbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      old_format,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  entry_t    pop_entry,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    phase_t      phase_reg;
    phase_t      phase_next;
    status_t     held_reg;
    status_t     held_next;
    logic [31:0] walk_reg;
    logic [31:0] walk_next;
    logic [31:0] prev_reg;
    logic [31:0] prev_next;
    logic        first_reg;
    logic        first_next;
    logic [31:0] bin_size_reg;
    logic [31:0] bin_size_next;
    logic [31:0] alloc_sum_reg;
    logic [31:0] alloc_sum_next;
    logic [31:0] free_sum_reg;
    logic [31:0] free_sum_next;
    logic [31:0] bin_user_reg;
    logic [31:0] bin_user_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;
    out_word_t   out_word_next;

    logic        pop;
    status_t     res_status;
    logic [31:0] res_offset;
    logic [32:0] fit_sum;
    logic        fit_bad;
    logic [31:0] alloc_sum_new;
    logic [31:0] free_sum_new;
    logic [31:0] bin_user_new;
    logic        first_link_bad;
    logic        link_bad;
    logic        bin_done;
    logic        fail;
    status_t     fail_code;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign fit_sum        = {1'b0, walk_reg} + {1'b0, pop_entry.mag};
    assign fit_bad        = (pop_entry.mag > bin_size_reg) || (fit_sum > {1'b0, bin_size_reg});
    assign alloc_sum_new  = alloc_sum_reg + pop_entry.mag;
    assign free_sum_new   = free_sum_reg + pop_entry.mag;
    assign bin_user_new   = bin_user_reg + pop_entry.user_delta;
    assign first_link_bad = old_format && first_reg && (pop_entry.back_link != NIL_LINK);
    assign link_bad       = old_format && !first_reg && (pop_entry.back_link != prev_reg);
    assign bin_done       = (fit_sum[31:0] >= bin_size_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        walk_next      = walk_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        bin_size_next  = bin_size_reg;
        alloc_sum_next = alloc_sum_reg;
        free_sum_next  = free_sum_reg;
        bin_user_next  = bin_user_reg;
        total_next     = total_reg;
        res_status     = ST_BUSY;
        res_offset     = '0;
        fail           = 1'b0;
        fail_code      = ST_BUSY;

        case (pop_entry.op)
            OP_CLEAR:
            begin
                total_next = '0;
            end
            OP_START_OPEN, OP_START_DONE, OP_START_BAD:
            begin
                bin_size_next  = pop_entry.bin_size;
                walk_next      = HEADER_BYTES;
                prev_next      = HEADER_BYTES;
                first_next     = 1'b1;
                alloc_sum_next = '0;
                free_sum_next  = '0;
                bin_user_next  = '0;
                held_next      = ST_BUSY;
                res_offset     = HEADER_BYTES;
                if (pop_entry.op == OP_START_OPEN)
                begin
                    phase_next = PH_OPEN;
                    res_status = ST_BUSY;
                end
                else if (pop_entry.op == OP_START_DONE)
                begin
                    phase_next = PH_IDLE;
                    res_status = ST_BIN_OK;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    res_status = ST_NO_BIN;
                end
            end
            OP_CELL:
            begin
                if (phase_reg == PH_FAIL)
                begin
                    res_status = held_reg;
                    res_offset = walk_reg;
                end
                else if (phase_reg != PH_OPEN)
                begin
                    res_status = ST_NO_BIN;
                end
                else if (first_link_bad)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_FIRST_LINK;
                end
                else if (link_bad)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_LINK;
                end
                else if (pop_entry.alloc && fit_bad)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_ALLOC;
                end
                else if (!pop_entry.alloc && (fit_bad || pop_entry.mag == '0))
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_FREE;
                end
                else
                begin
                    if (pop_entry.alloc)
                    begin
                        alloc_sum_next = alloc_sum_new;
                        bin_user_next  = bin_user_new;
                        if (alloc_sum_new > bin_size_reg)
                        begin
                            fail      = 1'b1;
                            fail_code = ST_ALLOC_OVERFLOW;
                        end
                    end
                    else
                    begin
                        free_sum_next = free_sum_new;
                        if (free_sum_new > bin_size_reg)
                        begin
                            fail      = 1'b1;
                            fail_code = ST_FREE_OVERFLOW;
                        end
                    end
                    if (!fail)
                    begin
                        prev_next  = walk_reg;
                        walk_next  = fit_sum[31:0];
                        first_next = 1'b0;
                        res_offset = walk_reg;
                        if (bin_done)
                        begin
                            total_next = total_reg + bin_user_next;
                            phase_next = PH_IDLE;
                            res_status = ST_BIN_OK;
                        end
                    end
                end
                if (fail)
                begin
                    held_next  = fail_code;
                    phase_next = PH_FAIL;
                    res_status = fail_code;
                    res_offset = walk_reg;
                end
            end
            default:
            begin
                res_status = ST_BUSY;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (pop)
        begin
            out_valid_next            = 1'b1;
            out_word_next.status      = res_status;
            out_word_next.cell_offset = res_offset;
            out_word_next.user_bytes  = total_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_reg      <= ST_BUSY;
            walk_reg      <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            bin_size_reg  <= '0;
            alloc_sum_reg <= '0;
            free_sum_reg  <= '0;
            bin_user_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            walk_reg      <= walk_next;
            prev_reg      <= prev_next;
            first_reg     <= first_next;
            bin_size_reg  <= bin_size_next;
            alloc_sum_reg <= alloc_sum_next;
            free_sum_reg  <= free_sum_next;
            bin_user_reg  <= bin_user_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    // A failed bin always holds one of the error codes of a cell check.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAIL |-> (held_reg == ST_BAD_FIRST_LINK || held_reg == ST_BAD_LINK
            || held_reg == ST_BAD_ALLOC || held_reg == ST_ALLOC_OVERFLOW
            || held_reg == ST_BAD_FREE || held_reg == ST_FREE_OVERFLOW))
        else $error("failed bin without a cell error code");

    // While a bin is open the walk has not yet reached its end.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OPEN |-> walk_reg < bin_size_reg)
        else $error("open bin with walk offset at or past bin size");

    // A clear word empties the running user total and reports it so.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_entry.op == OP_CLEAR |=> total_reg == '0 && out_word_reg.user_bytes == '0)
        else $error("clear did not empty the user total");

    // A new result is never loaded over one the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !pop)
        else $error("back end popped while result stalled");
`endif

endmodule

// ===== sv/cell_chain_bin_checker.sv =====
// Top level of the cell chain bin checker: front end, queue and back end.
//
// Usage: the input channel (in_valid, in_ready, in_word) carries one word per
// command: clear the running user total, start a bin with its size, or one
// cell header with its signed size and back-link. Every input word gives
// exactly one result word on the output channel (out_valid, out_ready,
// out_word) with a status code, the offset of the cell just checked and the
// running user byte total. The user writes the old_format_reg register via
// cfg_we and cfg_wdata only while no words are in flight; it is not enforced.
//
// The front end classifies each word and drops it into a four-entry queue;
// the back end takes one entry per cycle while the receiver keeps up, runs
// the fit, link and sum checks, and loads the result register. A word is
// registered in the queue and then in the result register before it shows
// on the output, and one word per cycle is sustained while the receiver
// does not stall.
//
// Reset leaves no bin open, clears all sums and the register. When the
// receiver stalls, the result register holds and the queue absorbs up to four
// more words before in_ready drops.
module cell_chain_bin_checker
    import ccbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic   old_format_reg;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    // The format register selects back-link checks and the user data offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_format_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            old_format_reg <= cfg_wdata;
        end
    end

    ccbc_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .old_format (old_format_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    ccbc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ccbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .old_format (old_format_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule

// ===== dv/bin_walk_checker.sv =====
// Checker for the cell chain bin checker: predicts every result word and compares.
`timescale 1ns / 100ps

module bin_walk_checker
    import ccbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output int        fault_count,
    output int        awaited_count
);

    localparam int REPORT_LIMIT = 10;

    // Own copy of the walk state and of the format register.
    logic        old_format;
    logic [31:0] walk_pos;
    logic [31:0] prev_cell;
    logic        first_pending;
    logic [31:0] bin_limit;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
    logic [31:0] bin_user;
    logic [31:0] run_user;
    phase_t      walk_phase;
    status_t     held_code;

    out_word_t   awaited_results[$];

    function automatic out_word_t result_of(input status_t code, input logic [31:0] offset);
        out_word_t r;
        r.status      = code;
        r.cell_offset = offset;
        r.user_bytes  = run_user;
        return r;
    endfunction

    // A failing cell holds its code until the next start.
    function automatic out_word_t fail_with(input status_t code);
        held_code  = code;
        walk_phase = PH_FAIL;
        return result_of(code, walk_pos);
    endfunction

    function automatic out_word_t next_bin_result(input in_word_t w);
        logic [31:0] pos;
        logic [31:0] mag;
        logic [31:0] user_skip;
        logic [32:0] reach;
        logic        alloc;
        case (cmd_t'(w.command))
            CMD_CLEAR:
            begin
                run_user = '0;
                return result_of(ST_BUSY, '0);
            end
            CMD_UNUSED:
                return result_of(ST_BUSY, '0);
            CMD_START:
            begin
                bin_limit     = w.bin_size;
                walk_pos      = HEADER_BYTES;
                prev_cell     = HEADER_BYTES;
                first_pending = 1'b1;
                alloc_total   = '0;
                free_total    = '0;
                bin_user      = '0;
                held_code     = ST_BUSY;
                if (w.bin_size > HEADER_BYTES)
                begin
                    walk_phase = PH_OPEN;
                    return result_of(ST_BUSY, walk_pos);
                end
                walk_phase = PH_IDLE;
                if (w.bin_size == HEADER_BYTES)
                    return result_of(ST_BIN_OK, walk_pos);
                return result_of(ST_NO_BIN, walk_pos);
            end
            default:
            begin
                if (walk_phase == PH_FAIL)
                    return result_of(held_code, walk_pos);
                if (walk_phase != PH_OPEN)
                    return result_of(ST_NO_BIN, '0);

                pos = walk_pos;
                if (old_format)
                begin
                    if (first_pending)
                    begin
                        if (w.back_link != NIL_LINK)
                            return fail_with(ST_BAD_FIRST_LINK);
                    end
                    else if (w.back_link != prev_cell)
                        return fail_with(ST_BAD_LINK);
                end

                alloc = w.cell_size[31];
                mag   = alloc ? 32'd0 - $unsigned(w.cell_size) : $unsigned(w.cell_size);
                reach = {1'b0, pos} + {1'b0, mag};

                if (alloc)
                begin
                    user_skip = old_format ? OLD_USER_OFFSET : NEW_USER_OFFSET;
                    if (mag > bin_limit || reach > {1'b0, bin_limit})
                        return fail_with(ST_BAD_ALLOC);
                    alloc_total = alloc_total + mag;
                    bin_user    = bin_user + mag - user_skip;
                    if (alloc_total > bin_limit)
                        return fail_with(ST_ALLOC_OVERFLOW);
                end
                else
                begin
                    if (mag > bin_limit || reach > {1'b0, bin_limit} || mag == '0)
                        return fail_with(ST_BAD_FREE);
                    free_total = free_total + mag;
                    if (free_total > bin_limit)
                        return fail_with(ST_FREE_OVERFLOW);
                end

                prev_cell     = pos;
                walk_pos      = pos + mag;
                first_pending = 1'b0;
                if (walk_pos >= bin_limit)
                begin
                    run_user   = run_user + bin_user;
                    walk_phase = PH_IDLE;
                    return result_of(ST_BIN_OK, pos);
                end
                return result_of(ST_BUSY, pos);
            end
        endcase
    endfunction

    task automatic note_fault(input string what, input out_word_t want, input out_word_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d offset %0d user %0d, got status %0d offset %0d user %0d",
                     $time, what, want.status, want.cell_offset, want.user_bytes,
                     got.status, got.cell_offset, got.user_bytes);
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (awaited_results.size() == 0)
        begin
            note_fault("result word with none awaited", '0, got);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.cell_offset !== want.cell_offset ||
            got.user_bytes !== want.user_bytes)
            note_fault("result word mismatch", want, got);
    endtask

    // Results are checked before the new word is predicted, so a stray result
    // can never be matched against a word accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_format    = 1'b0;
            walk_pos      = '0;
            prev_cell     = '0;
            first_pending = 1'b1;
            bin_limit     = '0;
            alloc_total   = '0;
            free_total    = '0;
            bin_user      = '0;
            run_user      = '0;
            walk_phase    = PH_IDLE;
            held_code     = ST_BUSY;
            awaited_results.delete();
            fault_count   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_word);
            if (in_valid && in_ready)
                awaited_results.push_back(next_bin_result(in_word));
            if (cfg_we)
                old_format = cfg_wdata;
        end
        awaited_count = awaited_results.size();
    end

endmodule

// ===== dv/cell_chain_bin_checker_test.sv =====
// Testbench top for the cell chain bin checker: stimulus, idling and verdict.
`timescale 1ns / 100ps

module cell_chain_bin_checker_test
    import ccbc_pkg::*;
();

    localparam int ITEM_GOAL    = 1950;
    localparam int DRAIN_CYCLES = 8;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;
    logic      cfg_we;
    logic      cfg_wdata;

    int fault_count;
    int awaited_count;

    // Idle rates in percent for the sender and the receiver; the main
    // sequence changes them between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;

    cell_chain_bin_checker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // The checker sits beside the block, watches both channels and reports
    // its failure count and the number of result words still outstanding.
    bin_walk_checker i_walk_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fault_count   (fault_count),
        .awaited_count (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs. A correct run needs far less time.
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The receiver decides at every falling edge whether it takes a word at
    // the next rising edge. With a zero idle rate it never stalls.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_word_t pack_word(input cmd_t cmd, input logic [31:0] bin,
                                           input logic [31:0] size_val,
                                           input logic [31:0] link);
        in_word_t w;
        w.command   = cmd;
        w.bin_size  = bin;
        w.cell_size = size_val;
        w.back_link = link;
        return w;
    endfunction

    // Presents one word at a falling edge and returns at the falling edge
    // after it was taken. Valid stays high into the next word unless the
    // sender decides to idle first.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_word(pack_word(cmd_t'($urandom_range(3)), $urandom(), $urandom(), $urandom()));
    endtask

    // The format register may only change while nothing is in flight, so the
    // sender holds off until every awaited result word has come back.
    task automatic set_format(input logic fmt);
        in_valid = 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = fmt;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Short hand-written sequence: empty and undersized bins, the extreme
    // cell sizes, the fit test past 2^32, held errors, restarts of an open
    // bin, a clear, and the link checks of the old layout.
    task automatic directed_words();
        set_format(1'b0);
        send_word(pack_word(CMD_CELL, '0, 32'd16, NIL_LINK));        // no bin open after reset
        send_word(pack_word(CMD_UNUSED, '1, '1, '1));
        send_word(pack_word(CMD_START, 32'd0, '0, '0));              // bin smaller than header
        send_word(pack_word(CMD_START, HEADER_BYTES, '0, '0));       // header-only bin
        send_word(pack_word(CMD_START, 32'hFFFF_FFFF, '0, '0));
        send_word(pack_word(CMD_CELL, '0, 32'h8000_0000, '0));       // most negative size
        send_word(pack_word(CMD_CELL, '0, 32'h8000_0000, '0));       // sum passes 2^32
        send_word(pack_word(CMD_CELL, '0, 32'd8, '0));               // held error again
        send_word(pack_word(CMD_START, 32'hFFFF_FFFF, '0, '0));
        send_word(pack_word(CMD_CELL, '0, -3, '0));                  // user bytes wrap
        send_word(pack_word(CMD_CELL, '0, 32'h7FFF_FFFF, '0));       // largest free cell
        send_word(pack_word(CMD_CELL, '0, 32'h7FFF_FFFF, '0));       // does not fit
        send_word(pack_word(CMD_START, 32'd64, '0, '0));
        send_word(pack_word(CMD_CELL, '0, 32'd0, '0));               // zero-size free cell
        send_word(pack_word(CMD_START, 32'd64, '0, '0));
        send_word(pack_word(CMD_CELL, '0, -16, '0));
        send_word(pack_word(CMD_START, 32'd64, '0, '0));             // restart an open bin
        send_word(pack_word(CMD_CELL, '0, -32, '0));                 // exact fill
        send_word(pack_word(CMD_CELL, '0, -8, '0));                  // bin already closed
        send_word(pack_word(CMD_CLEAR, '0, '0, '0));

        set_format(1'b1);
        send_word(pack_word(CMD_START, 32'd96, '0, '0));
        send_word(pack_word(CMD_CELL, '0, -16, NIL_LINK));
        send_word(pack_word(CMD_CELL, '0, 32'd16, HEADER_BYTES));
        send_word(pack_word(CMD_CELL, '0, -8, 32'd99));              // wrong back-link
        send_word(pack_word(CMD_START, 32'd96, '0, '0));
        send_word(pack_word(CMD_CELL, '0, -8, 32'd0));               // first link not nil
        send_word(pack_word(CMD_START, 32'd40, '0, '0));
        send_word(pack_word(CMD_CELL, '0, -8, NIL_LINK));
    endtask

    // One bin with a well-formed chain of random cells. Now and then a
    // broken cell, an oversize cell, a clear, an unused command or an early restart is mixed in;
    // after a broken cell up to two noise words follow and the bin is left.
    task automatic random_bin();
        logic [31:0] limit;
        logic [31:0] pos;
        logic [31:0] prev;
        logic [31:0] rem;
        logic [31:0] mag;
        logic [31:0] link;
        logic [31:0] size_field;
        logic        first;
        logic        alloc;
        logic        broken;
        int          roll;
        int          cells;

        roll = $urandom_range(99);
        if (roll < 8)
            limit = $urandom();
        else if (roll < 14)
            limit = $urandom_range(0, HEADER_BYTES + 1);
        else
            limit = HEADER_BYTES + $urandom_range(1, 160);
        send_word(pack_word(CMD_START, limit, $urandom(), $urandom()));

        pos   = HEADER_BYTES;
        prev  = HEADER_BYTES;
        first = 1'b1;
        cells = 0;
        while (pos < limit && cells < 40)
        begin
            rem = limit - pos;
            if (rem > 32'h7FFF_FFFF)
                mag = $urandom_range(1, 32'h7FFF_FFFF);
            else if (cells >= 3 && $urandom_range(1) == 1)
                mag = rem;
            else
                mag = $urandom_range(1, rem);
            alloc  = $urandom_range(1);
            link   = first ? NIL_LINK : prev;
            broken = 1'b0;

            roll = $urandom_range(99);
            if (roll < 4)
            begin
                link   = $urandom();
                broken = 1'b1;
            end
            else if (roll < 7)
            begin
                mag    = '0;
                alloc  = 1'b0;
                broken = 1'b1;
            end
            else if (roll < 10)
            begin
                mag    = rem + $urandom_range(1, 64);
                broken = 1'b1;
            end
            else if (roll < 12)
                send_word(pack_word(CMD_CLEAR, $urandom(), $urandom(), $urandom()));
            else if (roll < 13)
                send_word(pack_word(CMD_UNUSED, $urandom(), $urandom(), $urandom()));
            else if (roll < 14)
                return;

            size_field = alloc ? 32'd0 - mag : mag;
            send_word(pack_word(CMD_CELL, $urandom(), size_field, link));
            if (broken)
            begin
                repeat ($urandom_range(0, 2))
                    send_word(pack_word(CMD_CELL, $urandom(), $urandom(), $urandom()));
                return;
            end
            prev  = pos;
            pos   = pos + mag;
            first = 1'b0;
            cells++;
        end

        // A cell after a finished bin finds no open bin.
        if ($urandom_range(4) == 0)
            send_word(pack_word(CMD_CELL, $urandom(), $urandom(), $urandom()));
    endtask

    initial
    begin
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        rst_n     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        directed_words();

        // Three idling phases: sender idles more lightly first, then the
        // receiver does, then neither idles. Each phase runs both layouts.
        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle_pct = (phase_no == 0) ? 34 : (phase_no == 1) ? 57 : 0;
            recv_idle_pct = (phase_no == 0) ? 57 : (phase_no == 1) ? 34 : 0;
            for (int half = 0; half < 2; half++)
            begin
                set_format(((phase_no + half) % 2) == 1);
                while (words_sent < ITEM_GOAL * (phase_no * 2 + half + 1) / 6)
                begin
                    if ($urandom_range(9) == 0)
                        send_noise();
                    else
                        random_bin();
                end
            end
        end

        // Let every awaited word come back, then keep the clock running for a drain
        // period so that anything stray can show up before the verdict.
        in_valid = 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0 && awaited_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
